FILE: design/brc_pkg.sv
`default_nettype none
package brc_pkg;
	localparam int WEIGHT_BITS = 32;
	localparam int WB = WEIGHT_BITS;
	// Dividend width: base (64) times (2m-c)*c (2*WB).
	localparam int NB = 64 + 2 * WB;
	// Quotient after first division: at most base * m.
	localparam int QB = 64 + WB;
	localparam int NCELL = NB + QB;
	localparam int DEPTH = NCELL + 2;

	localparam logic [1:0] REG_SUPPLY = 2'd0;
	localparam logic [1:0] REG_SHIFT  = 2'd1;
	localparam logic [1:0] REG_TAIL   = 2'd2;
	localparam logic [1:0] REG_ZONE   = 2'd3;

	typedef struct packed {
		logic          pen;
		logic          too_big;
		logic [63:0]   base;
		logic [WB-1:0] m;
		logic [NB-1:0] num;
		logic [NB-1:0] quo;
		logic [WB:0]   rem;
	} div_tok_t;
endpackage
`default_nettype wire

FILE: design/brc_div_cell.sv
`default_nettype none
// One restoring division step: brings in one dividend bit, subtracts if possible.
module brc_div_cell (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire logic                  vin,
	input  wire brc_pkg::div_tok_t     din,
	output logic                       vout,
	output brc_pkg::div_tok_t          dout
);
	brc_pkg::div_tok_t nxt;
	logic [brc_pkg::WB+1:0] sh;
	logic [brc_pkg::WB+1:0] diff;

	always_comb begin
		nxt = din;
		sh = {din.rem, din.num[brc_pkg::NB-1]};
		diff = sh - {2'b00, din.m};
		nxt.num = {din.num[brc_pkg::NB-2:0], 1'b0};
		if (!diff[brc_pkg::WB+1]) begin
			nxt.rem = diff[brc_pkg::WB:0];
			nxt.quo = {din.quo[brc_pkg::NB-2:0], 1'b1};
		end else begin
			nxt.rem = sh[brc_pkg::WB:0];
			nxt.quo = {din.quo[brc_pkg::NB-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout <= 1'b0;
		end else if (en) begin
			vout <= vin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end
endmodule
`default_nettype wire

FILE: design/brc_mul.sv
`default_nettype none
// 64 x 64 product split into four 32x32 partial products, summed a stage later.
module brc_mul (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic [63:0]              a,
	input  wire logic [2*brc_pkg::WB-1:0] b,
	output logic [brc_pkg::NB-1:0]        p
);
	logic [63:0] b64;
	logic [63:0] pp_s1 [4];

	assign b64 = 64'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			pp_s1[0] <= a[31:0]  * b64[31:0];
			pp_s1[1] <= a[31:0]  * b64[63:32];
			pp_s1[2] <= a[63:32] * b64[31:0];
			pp_s1[3] <= a[63:32] * b64[63:32];
		end
	end

	always_comb begin
		p = brc_pkg::NB'({64'd0, pp_s1[0]} + ({64'd0, pp_s1[1]} << 32)
			+ ({64'd0, pp_s1[2]} << 32) + ({64'd0, pp_s1[3]} << 64));
	end
endmodule
`default_nettype wire

FILE: design/block_reward_calculator.sv
`default_nettype none
// Throughput: one item per cycle unless the output stalls; a chain of one-bit
// restoring division cells, NB cells for the first division by the median and
// QB for the second, sets the depth.
// Reset (arst_n, asynchronous, low) empties the pipeline and restores register defaults.
// The whole pipeline advances when the output register is empty or being taken.
module block_reward_calculator (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] median_wt,
	input  wire logic [31:0] block_weight,
	input  wire logic [63:0] coins_generated,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      reward_amount,
	output logic             too_big
);
	localparam int WB = brc_pkg::WB;
	localparam int NB = brc_pkg::NB;
	localparam int NC = brc_pkg::NCELL;

	logic [63:0]   supply_q;
	logic [5:0]    shift_q;
	logic [62:0]   tail_q;
	logic [WB-1:0] zone_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			supply_q <= 64'hFFFF_FFFF_FFFF_FFFF;
			shift_q  <= 6'd19;
			tail_q   <= 63'd300000000000;
			zone_q   <= WB'(300000);
		end else if (cfg_we) begin
			case (cfg_index)
				brc_pkg::REG_SUPPLY: supply_q <= cfg_data;
				brc_pkg::REG_SHIFT:  shift_q  <= cfg_data[5:0];
				brc_pkg::REG_TAIL:   tail_q   <= cfg_data[62:0];
				brc_pkg::REG_ZONE:   zone_q   <= cfg_data[WB-1:0];
				default: ;
			endcase
		end
	end

	// The pipeline moves as one when the output slot is free.
	logic en;
	assign en = !out_valid || !out_stall;
	assign in_stall = !en;

	// Stage 1: base reward, clamped median, classification.
	logic [WB-1:0] m_in, c_in, m_eff;
	logic [63:0]   remaining, base_c, floor_c, base_sel;
	assign m_in = median_wt[WB-1:0];
	assign c_in = block_weight[WB-1:0];
	assign m_eff = (m_in < zone_q) ? zone_q : m_in;
	assign remaining = (coins_generated > supply_q) ? 64'd0 : supply_q - coins_generated;
	assign base_c = (remaining >> shift_q) >> 3;
	assign floor_c = {tail_q, 1'b0} >> 3;
	always_comb begin
		if (coins_generated == 64'd0) begin
			base_sel = supply_q >> shift_q;
		end else if (base_c < floor_c) begin
			base_sel = floor_c;
		end else begin
			base_sel = base_c;
		end
	end

	logic          v_s1, full_s1, big_s1;
	logic [63:0]   base_s1;
	logic [WB-1:0] m_s1;
	logic [WB:0]   k_s1;
	logic [WB-1:0] c_s1;
	logic [WB:0]   twom;
	assign twom = {m_eff, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			base_s1 <= base_sel;
			m_s1    <= m_eff;
			full_s1 <= c_in <= m_eff;
			big_s1  <= {1'b0, c_in} > twom;
			k_s1    <= twom - {1'b0, c_in};
			c_s1    <= c_in;
		end
	end

	// Stage 2: multiplier (k*c) then wide product inside brc_mul.
	logic          v_s2, full_s2, big_s2;
	logic [63:0]   base_s2;
	logic [WB-1:0] m_s2;
	logic [2*WB-1:0] kc_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			base_s2 <= base_s1;
			m_s2    <= m_s1;
			full_s2 <= full_s1;
			big_s2  <= big_s1;
			kc_s2   <= {{WB{1'b0}}, k_s1[WB-1:0]} * {{WB{1'b0}}, c_s1};
		end
	end

	logic [NB-1:0] prod;
	brc_mul u_mul (.clk(clk), .en(en), .a(base_s2), .b(kc_s2), .p(prod));

	logic          v_s3, full_s3, big_s3;
	logic [63:0]   base_s3;
	logic [WB-1:0] m_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			base_s3 <= base_s2;
			m_s3    <= m_s2;
			full_s3 <= full_s2;
			big_s3  <= big_s2;
		end
	end

	// Division chain. A zero median only reaches here for full or too-big items,
	// whose quotient is ignored.
	brc_pkg::div_tok_t tok [NC+1];
	logic              tv  [NC+1];
	always_comb begin
		tok[0] = '0;
		tok[0].pen = !full_s3 && !big_s3;
		tok[0].too_big = big_s3;
		tok[0].base = base_s3;
		tok[0].m = m_s3;
		tok[0].num = prod;
		tv[0] = v_s3;
	end

	for (genvar i = 0; i < NC; i++) begin : g_cell
		brc_pkg::div_tok_t cin;
		always_comb begin
			cin = tok[i];
			// Between the two divisions, restart with the first quotient.
			if (i == NB) begin
				cin.num = tok[i].quo << (NB - brc_pkg::QB);
				cin.quo = '0;
				cin.rem = '0;
			end
		end
		brc_div_cell u_cell (.clk(clk), .arst_n(arst_n), .en(en), .vin(tv[i]),
			.din(cin), .vout(tv[i+1]), .dout(tok[i+1]));
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= tv[NC];
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			too_big <= tok[NC].too_big;
			if (tok[NC].too_big) begin
				reward_amount <= 64'd0;
			end else if (tok[NC].pen) begin
				reward_amount <= tok[NC].quo[63:0];
			end else begin
				reward_amount <= tok[NC].base;
			end
		end
	end
endmodule
`default_nettype wire

FILE: design/brc_checker.sv
`default_nettype none
module brc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [63:0] reward_amount,
	input wire logic        too_big
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(reward_amount))
		else $error("stalled result changed");
	a_big_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && too_big |-> reward_amount == 64'd0)
		else $error("too big block with reward");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output free");
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("stall with empty output");
endmodule

bind block_reward_calculator brc_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_valid(in_valid), .in_stall(in_stall), .out_valid(out_valid),
	.out_stall(out_stall), .reward_amount(reward_amount), .too_big(too_big));
`default_nettype wire

FILE: tb/tb_block_reward_calculator.sv
`timescale 1ns / 100ps
`default_nettype none
// Stimulus, prediction and checking for the block reward calculator.
// An initial block runs the test in phases. Each phase first writes the registers
// while the block is idle, then queues reward requests. A clocked driver feeds
// those requests into the input port. A clocked monitor takes the results and
// compares each one with the oldest expected reward.
module tb_block_reward_calculator;
	localparam int LATENCY   = brc_pkg::DEPTH + 1;
	localparam int WATCHDOG  = 6000;
	localparam int LONG_HOLD = 700;

	typedef struct {
		logic [31:0] median;
		logic [31:0] weight;
		logic [63:0] coins;
	} request_t;

	typedef struct {
		logic [63:0] reward;
		logic        big;
	} reward_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = brc_pkg::REG_SUPPLY;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] median_wt = '0;
	logic [31:0] block_weight = '0;
	logic [63:0] coins_generated = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] reward_amount;
	logic        too_big;

	block_reward_calculator dut (.*);

	// The testbench's own copy of the registers, changed only while the block is idle.
	logic [63:0] supply_r;
	logic [5:0]  shift_r;
	logic [62:0] tail_r;
	logic [31:0] zone_r;

	request_t pending_requests[$];
	reward_t  expected_rewards[$];
	int       errors = 0;
	int       results_taken = 0;
	int       idle_cycles = 0;
	int       send_gap = 0;
	int       take_gap = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Computes the reward for one request under the current register settings.
	function automatic reward_t compute_reward(request_t rq);
		logic [63:0]  m, c, remaining, base, floor_v, mult;
		logic [127:0] wide;
		reward_t      r;
		m = {32'd0, rq.median};
		c = {32'd0, rq.weight};
		remaining = (rq.coins > supply_r) ? 64'd0 : supply_r - rq.coins;
		base = (remaining >> shift_r) >> 3;
		floor_v = {tail_r, 1'b0} >> 3;
		if (base < floor_v)
			base = floor_v;
		// With nothing generated yet there is no floor and no extra shift.
		if (rq.coins == 64'd0)
			base = supply_r >> shift_r;
		if (m < {32'd0, zone_r})
			m = {32'd0, zone_r};
		r.big = 1'b0;
		if (c <= m) begin
			r.reward = base;
		end else if (c > 2 * m) begin
			r.reward = 64'd0;
			r.big = 1'b1;
		end else begin
			mult = (2 * m - c) * c;
			wide = {64'd0, base} * {64'd0, mult};
			wide = wide / {64'd0, m};
			wide = wide / {64'd0, m};
			r.reward = wide[63:0];
		end
		return r;
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 19);
		if (r < 11)
			return 0;
		else if (r < 18)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver: a new request is offered only once the previous transfer has completed,
	// so a stalled payload stays put. The prediction is made at the transfer itself.
	always @(posedge clk or negedge arst_n) begin
		request_t rq;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				rq.median = median_wt;
				rq.weight = block_weight;
				rq.coins = coins_generated;
				expected_rewards.insert(expected_rewards.size(), compute_reward(rq));
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_requests.size() > 0) begin
					rq = pending_requests.pop_front();
					in_valid <= 1'b1;
					median_wt <= rq.median;
					block_weight <= rq.weight;
					coins_generated <= rq.coins;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result transfer against the oldest expectation. Once, after
	// a hundred results, the output is held off long enough for a result to wait there;
	// the whole pipeline then halts and the input must stall.
	always @(posedge clk or negedge arst_n) begin
		reward_t exp_r;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_taken++;
				if (expected_rewards.size() == 0) begin
					errors++;
					$display("%0t: unexpected result reward=%0d too_big=%0b",
						$time, reward_amount, too_big);
				end else begin
					exp_r = expected_rewards.pop_front();
					if (reward_amount !== exp_r.reward) begin
						errors++;
						$display("%0t: reward_amount expected %0d, actual %0d",
							$time, exp_r.reward, reward_amount);
					end
					if (too_big !== exp_r.big) begin
						errors++;
						$display("%0t: too_big expected %0b, actual %0b",
							$time, exp_r.big, too_big);
					end
				end
			end
			if (!hold_done && results_taken >= 100) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (take_gap > 0) begin
				take_gap--;
				out_stall <= 1'b1;
			end else begin
				take_gap = pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: counts cycles in which neither side completes a transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("** block_reward_calculator: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			brc_pkg::REG_SUPPLY: supply_r = value;
			brc_pkg::REG_SHIFT:  shift_r = value[5:0];
			brc_pkg::REG_TAIL:   tail_r = value[62:0];
			default:             zone_r = value[31:0];
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_regs(input logic [63:0] s, input logic [5:0] sh,
			input logic [62:0] t, input logic [31:0] z);
		write_reg(brc_pkg::REG_SUPPLY, s);
		write_reg(brc_pkg::REG_SHIFT, {58'd0, sh});
		write_reg(brc_pkg::REG_TAIL, {1'b0, t});
		write_reg(brc_pkg::REG_ZONE, {32'd0, z});
	endtask

	task automatic queue_request(input logic [31:0] m, input logic [31:0] c,
			input logic [63:0] coins);
		request_t rq;
		rq.median = m;
		rq.weight = c;
		rq.coins = coins;
		pending_requests.insert(pending_requests.size(), rq);
	endtask

	// Waits for every request to be sent and every reward to arrive, then for the
	// pipeline latency so that the block is idle before registers change.
	task automatic drain();
		while (pending_requests.size() > 0 || in_valid || expected_rewards.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random requests, weighted towards the penalty zone between m and 2m where the
	// division chain does the real work.
	task automatic queue_random(input int count);
		logic [31:0] m, c;
		logic [63:0] coins, span;
		int          kind;
		repeat (count) begin
			kind = $urandom_range(0, 9);
			case ($urandom_range(0, 3))
				0: m = $urandom();
				1: m = $urandom_range(0, 1000);
				2: m = zone_r + $urandom_range(0, 50000);
				default: m = $urandom_range(0, 600000);
			endcase
			if (kind < 6) begin
				span = {32'd0, m};
				c = m + 32'(($urandom() % (span + 64'd1)));
				if ({32'd0, m} + span > 64'hFFFF_FFFF)
					c = m + 32'($urandom_range(0, 100));
			end else if (kind < 8) begin
				c = $urandom();
			end else begin
				c = $urandom_range(0, 300000);
			end
			case ($urandom_range(0, 7))
				0: coins = 64'd0;
				1: coins = supply_r + $urandom_range(0, 3);
				2: coins = 64'hFFFF_FFFF_FFFF_FFFF;
				default: coins = rand64();
			endcase
			queue_request(m, c, coins);
		end
	endtask

	initial begin
		supply_r = 64'hFFFF_FFFF_FFFF_FFFF;
		shift_r = 6'd19;
		tail_r = 63'd300000000000;
		zone_r = 32'd300000;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Defaults, with the directed corners: field extremes, zero coins, coins
		// equal to supply, median raised to the zone, full, penalised and too-big blocks.
		set_regs(64'hFFFF_FFFF_FFFF_FFFF, 6'd19, 63'd300000000000, 32'd300000);
		queue_request(32'd0, 32'd0, 64'd0);
		queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_request(32'hFFFF_FFFF, 32'd0, 64'd1);
		queue_request(32'd0, 32'hFFFF_FFFF, 64'd12345);
		queue_request(32'd100, 32'd300000, 64'd5);
		queue_request(32'd100, 32'd300001, 64'd5);
		queue_request(32'd300000, 32'd600000, 64'd5);
		queue_request(32'd300000, 32'd600001, 64'd5);
		queue_request(32'd400000, 32'd500000, 64'd0);
		queue_request(32'd400000, 32'd799999, 64'hFFFF_FFFF_FFFF_FFFE);
		queue_request(32'h8000_0000, 32'hFFFF_FFFF, 64'h8000_0000_0000_0000);
		queue_random(280);
		drain();

		// Zero zone, zero shift and widest tail: zero median makes any nonzero weight too big.
		set_regs(64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 63'h7FFF_FFFF_FFFF_FFFF, 32'd0);
		queue_request(32'd0, 32'd0, 64'd7);
		queue_request(32'd0, 32'd1, 64'd7);
		queue_request(32'd1, 32'd2, 64'd0);
		queue_request(32'd3, 32'd5, 64'd9);
		queue_request(32'hFFFF_FFFF, 32'hFFFF_FFFE, 64'd0);
		queue_random(280);
		drain();

		set_regs(64'd0, 6'd63, 63'd0, 32'hFFFF_FFFF);
		queue_request(32'd0, 32'hFFFF_FFFF, 64'd0);
		queue_request(32'd5, 32'd5, 64'd1);
		queue_random(280);
		drain();

		repeat (3) begin
			set_regs(rand64(), 6'($urandom_range(0, 40)),
				63'({$urandom(), $urandom()} >> 1), $urandom_range(0, 1000000));
			queue_random(120);
			drain();
		end

		if (errors == 0)
			$display("** block_reward_calculator: PASSED **");
		else
			$display("** block_reward_calculator: FAILED **");
		$finish;
	end
endmodule
`default_nettype wire

FILE: filelist.f
design/brc_pkg.sv
design/brc_div_cell.sv
design/brc_mul.sv
design/block_reward_calculator.sv
design/brc_checker.sv
tb/tb_block_reward_calculator.sv
